### src/htb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_pkg
// shared constants and types for the huffman tree builder
// ----------------------------------------------------------------------------
package htb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int WEIGHT_BITS = 24;

    localparam int IDX_W  = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int TAG_W  = 8;
    localparam int WIN_W  = 24;
    localparam int SUM_W  = 30;
    localparam int NODE_W = 6;

    localparam logic [WIN_W-1:0] WEIGHT_MASK = WIN_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

    typedef struct packed {
        logic [SUM_W-1:0] weight;
        logic             is_leaf;
        logic [TAG_W-1:0] id;
    } entry_t;

    typedef struct packed {
        logic             clear;
        logic             sample;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic             v1;
        logic             v2;
        logic [IDX_W-1:0] i1;
        logic [IDX_W-1:0] i2;
        entry_t           e1;
        entry_t           e2;
    } pick_t;

    typedef struct packed {
        logic              left_is_leaf;
        logic [TAG_W-1:0]  left_id;
        logic              right_is_leaf;
        logic [TAG_W-1:0]  right_id;
        logic [NODE_W-1:0] node_number;
        logic [SUM_W-1:0]  node_weight;
        logic              lone_leaf;
        logic              dropped;
        logic              final_res;
    } res_t;

endpackage

### src/htb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_in_if
// symbol channel: one weighted leaf per beat
// ----------------------------------------------------------------------------
interface htb_in_if;
    logic                      valid;
    logic                      ready;
    logic [htb_pkg::TAG_W-1:0] symbol_tag;
    logic [htb_pkg::WIN_W-1:0] weight;
    logic                      last_symbol;

    modport source (output valid, output symbol_tag, output weight, output last_symbol,
                    input ready);
    modport sink   (input valid, input symbol_tag, input weight, input last_symbol,
                    output ready);
endinterface

### src/htb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_out_if
// merge result channel: one tree node per beat
// ----------------------------------------------------------------------------
interface htb_out_if;
    logic                       valid;
    logic                       ready;
    logic                       left_is_leaf;
    logic [htb_pkg::TAG_W-1:0]  left_id;
    logic                       right_is_leaf;
    logic [htb_pkg::TAG_W-1:0]  right_id;
    logic [htb_pkg::NODE_W-1:0] node_number;
    logic [htb_pkg::SUM_W-1:0]  node_weight;
    logic                       lone_leaf;
    logic                       dropped;
    logic                       final_res;

    modport source (output valid, output left_is_leaf, output left_id,
                    output right_is_leaf, output right_id, output node_number,
                    output node_weight, output lone_leaf, output dropped,
                    output final_res, input ready);
    modport sink   (input valid, input left_is_leaf, input left_id,
                    input right_is_leaf, input right_id, input node_number,
                    input node_weight, input lone_leaf, input dropped,
                    input final_res, output ready);
endinterface

### src/htb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module htb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/htb_min2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htb_min2
// scan compare unit: tracks first strict minimum and first minimum of the rest
// ----------------------------------------------------------------------------
module htb_min2 (
    input  logic               clk,
    input  logic               rst_n,
    input  htb_pkg::scan_ctl_t ctl,
    input  htb_pkg::entry_t    data,
    output htb_pkg::pick_t     pick
);

    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic [htb_pkg::IDX_W-1:0] i1_reg, i1_next;
    logic [htb_pkg::IDX_W-1:0] i2_reg, i2_next;
    htb_pkg::entry_t           e1_reg, e1_next;
    htb_pkg::entry_t           e2_reg, e2_next;

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        i1_next = i1_reg;
        i2_next = i2_reg;
        e1_next = e1_reg;
        e2_next = e2_reg;
        if (ctl.clear)
        begin
            v1_next = 1'b0;
            v2_next = 1'b0;
        end
        else if (ctl.sample)
        begin
            if (!v1_reg || (data.weight < e1_reg.weight))
            begin
                // old best moves down to second place
                if (v1_reg)
                begin
                    v2_next = 1'b1;
                    i2_next = i1_reg;
                    e2_next = e1_reg;
                end
                v1_next = 1'b1;
                i1_next = ctl.idx;
                e1_next = data;
            end
            else if (!v2_reg || (data.weight < e2_reg.weight))
            begin
                v2_next = 1'b1;
                i2_next = ctl.idx;
                e2_next = data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg <= i1_next;
        i2_reg <= i2_next;
        e1_reg <= e1_next;
        e2_reg <= e2_next;
    end

    assign pick.v1 = v1_reg;
    assign pick.v2 = v2_reg;
    assign pick.i1 = i1_reg;
    assign pick.i2 = i2_reg;
    assign pick.e1 = e1_reg;
    assign pick.e2 = e2_reg;

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> v1_reg)
        else $error("second minimum valid without first");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (e1_reg.weight <= e2_reg.weight))
        else $error("first minimum above second");

    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (i1_reg != i2_reg))
        else $error("both minima on the same slot");

endmodule

### src/huffman_tree_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_builder
// loads weighted leaves into a list ram and merges the two lightest entries
// until one node is left, emitting a lone leaf beat or one beat per merge
// ----------------------------------------------------------------------------
// sequence: a load beat writes one leaf; a lone leaf is read, then output; a merge
//   scans the live entries, writes the merged pair and closes up the entries
//   above the higher slot; merge and lone leaf output stall while a beat is held
// throughput: not ready from a set's last beat until root merge or lone leaf is done
// reset: clears the sequencer, counts and flags; no list clearing pass
// ----------------------------------------------------------------------------
module huffman_tree_builder (
    input  logic clk,
    input  logic rst_n,
    htb_in_if.sink    sym,
    htb_out_if.source res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LONE_RD,
        ST_LONE_OUT,
        ST_SCAN,
        ST_MERGE,
        ST_SHIFT
    } state_t;

    state_t                     state_reg, state_next;
    logic [htb_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [htb_pkg::NODE_W-1:0] node_reg, node_next;
    logic                       ovf_reg, ovf_next;
    logic [htb_pkg::CNT_W-1:0]  addr_reg, addr_next;
    logic                       rv_reg, rv_next;
    logic [htb_pkg::IDX_W-1:0]  ridx_reg, ridx_next;
    logic                       out_valid_reg, out_valid_next;
    htb_pkg::res_t              res_reg, res_next;

    logic                       we;
    logic [htb_pkg::IDX_W-1:0]  waddr;
    htb_pkg::entry_t            wdata;
    htb_pkg::entry_t            rdata;
    htb_pkg::scan_ctl_t         mctl;
    htb_pkg::pick_t             pick;

    logic                       full;
    logic [htb_pkg::CNT_W-1:0]  count_after;
    logic                       out_free;
    logic [htb_pkg::SUM_W:0]    sum_full;
    logic [htb_pkg::SUM_W-1:0]  sum_sat;
    logic [htb_pkg::IDX_W-1:0]  lo_idx;
    logic [htb_pkg::IDX_W-1:0]  hi_idx;

    htb_ram #(
        .WIDTH ($bits(htb_pkg::entry_t)),
        .DEPTH (htb_pkg::MAX_SYMBOLS)
    ) u_list (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg[htb_pkg::IDX_W-1:0]),
        .rdata (rdata)
    );

    htb_min2 u_min2 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .data  (rdata),
        .pick  (pick)
    );

    assign full        = (count_reg == htb_pkg::CNT_W'(htb_pkg::MAX_SYMBOLS));
    assign count_after = full ? count_reg : count_reg + 1'b1;
    assign out_free    = !out_valid_reg || res.ready;
    assign sum_full    = {1'b0, pick.e1.weight} + {1'b0, pick.e2.weight};
    assign sum_sat     = sum_full[htb_pkg::SUM_W] ? htb_pkg::SUM_MAX
                                                  : sum_full[htb_pkg::SUM_W-1:0];
    assign lo_idx      = (pick.i1 < pick.i2) ? pick.i1 : pick.i2;
    assign hi_idx      = (pick.i1 < pick.i2) ? pick.i2 : pick.i1;

    assign sym.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        node_next  = node_reg;
        ovf_next   = ovf_reg;
        addr_next  = addr_reg;
        rv_next    = 1'b0;
        ridx_next  = ridx_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = count_reg[htb_pkg::IDX_W-1:0];
        wdata      = '0;
        mctl       = '0;
        out_valid_next = out_valid_reg && !res.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (sym.valid)
                begin
                    if (!full)
                    begin
                        we            = 1'b1;
                        waddr         = count_reg[htb_pkg::IDX_W-1:0];
                        wdata.weight  = htb_pkg::SUM_W'(sym.weight & htb_pkg::WEIGHT_MASK);
                        wdata.is_leaf = 1'b1;
                        wdata.id      = sym.symbol_tag;
                        count_next    = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (sym.last_symbol)
                    begin
                        addr_next = '0;
                        if (count_after == htb_pkg::CNT_W'(1))
                        begin
                            state_next = ST_LONE_RD;
                        end
                        else
                        begin
                            mctl.clear = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_LONE_RD:
            begin
                state_next = ST_LONE_OUT;
            end

            ST_LONE_OUT:
            begin
                if (out_free)
                begin
                    res_next.left_is_leaf  = rdata.is_leaf;
                    res_next.left_id       = rdata.id;
                    res_next.right_is_leaf = 1'b0;
                    res_next.right_id      = '0;
                    res_next.node_number   = '0;
                    res_next.node_weight   = rdata.weight;
                    res_next.lone_leaf     = 1'b1;
                    res_next.dropped       = ovf_reg;
                    res_next.final_res     = 1'b1;
                    out_valid_next         = 1'b1;
                    count_next             = '0;
                    node_next              = '0;
                    ovf_next               = 1'b0;
                    state_next             = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                mctl.sample = rv_reg;
                mctl.idx    = ridx_reg;
                if (addr_reg < count_reg)
                begin
                    rv_next   = 1'b1;
                    ridx_next = addr_reg[htb_pkg::IDX_W-1:0];
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    state_next = ST_MERGE;
                end
            end

            ST_MERGE:
            begin
                if (out_free)
                begin
                    res_next.left_is_leaf  = pick.e1.is_leaf;
                    res_next.left_id       = pick.e1.id;
                    res_next.right_is_leaf = pick.e2.is_leaf;
                    res_next.right_id      = pick.e2.id;
                    res_next.node_number   = node_reg;
                    res_next.node_weight   = sum_sat;
                    res_next.lone_leaf     = 1'b0;
                    res_next.dropped       = ovf_reg;
                    res_next.final_res     = (count_reg == htb_pkg::CNT_W'(2));
                    out_valid_next         = 1'b1;
                    we            = 1'b1;
                    waddr         = lo_idx;
                    wdata.weight  = sum_sat;
                    wdata.is_leaf = 1'b0;
                    wdata.id      = htb_pkg::TAG_W'(node_reg);
                    node_next     = node_reg + 1'b1;
                    addr_next     = htb_pkg::CNT_W'(hi_idx) + 1'b1;
                    state_next    = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // close up the list behind the freed slot
                if (rv_reg)
                begin
                    we    = 1'b1;
                    waddr = ridx_reg - 1'b1;
                    wdata = rdata;
                end
                if (addr_reg < count_reg)
                begin
                    rv_next   = 1'b1;
                    ridx_next = addr_reg[htb_pkg::IDX_W-1:0];
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    if (count_reg == htb_pkg::CNT_W'(2))
                    begin
                        count_next = '0;
                        node_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        addr_next  = '0;
                        mctl.clear = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            node_reg      <= '0;
            ovf_reg       <= 1'b0;
            addr_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            node_reg      <= node_next;
            ovf_reg       <= ovf_next;
            addr_reg      <= addr_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        res_reg  <= res_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.left_is_leaf  = res_reg.left_is_leaf;
    assign res.left_id       = res_reg.left_id;
    assign res.right_is_leaf = res_reg.right_is_leaf;
    assign res.right_id      = res_reg.right_id;
    assign res.node_number   = res_reg.node_number;
    assign res.node_weight   = res_reg.node_weight;
    assign res.lone_leaf     = res_reg.lone_leaf;
    assign res.dropped       = res_reg.dropped;
    assign res.final_res     = res_reg.final_res;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= htb_pkg::CNT_W'(htb_pkg::MAX_SYMBOLS))
        else $error("live count beyond capacity");

    a_merge_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (pick.v1 && pick.v2 && count_reg >= htb_pkg::CNT_W'(2)))
        else $error("merge without two live entries");

    a_shift_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && rv_reg) |-> (ridx_reg != '0))
        else $error("close-up write below slot zero");

endmodule
